[design/hbe_pkg.sv]
// Shared types and constants for the Huffman byte encoder.
package hbe_pkg;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int ACC_W  = 7;
    localparam int FILL_W = 3;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = ACC_W + CODE_W;
    localparam int CNT_W  = 3;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // One table entry as seen by the packing stage; length zero means no code.
    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } t_entry;

endpackage

[design/hbe_ifs.sv]
// Valid/ready channel interfaces for the encoder's input and result words.
interface hbe_in_if import hbe_pkg::*; ();
    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, command, symbol, code_value, code_length, input ready);
    modport sink   (input valid, command, symbol, code_value, code_length, output ready);
endinterface

interface hbe_out_if import hbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] packed_byte;
    logic              last;

    modport source (output valid, kind, packed_byte, last, input ready);
    modport sink   (input valid, kind, packed_byte, last, output ready);
endinterface

[design/hbe_code_table.sv]
// Code table: code and length memories with per-entry valid bits and a registered read.
module hbe_code_table import hbe_pkg::*; #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [SYM_W-1:0]  i_sym,
    input  logic [CODE_W-1:0] i_code,
    input  logic [LEN_W-1:0]  i_length,
    output t_entry            o_entry
);

    localparam int AW        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

    logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
    logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_valid;

    logic [LEN_W-1:0]  r_rd_len;
    logic [CODE_W-1:0] r_rd_code;
    logic              r_rd_hit;

    logic              in_range;
    logic [AW-1:0]     idx;
    logic [LEN_W-1:0]  sat_len;

    assign in_range = {1'b0, i_sym} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign idx      = i_sym[AW-1:0];
    assign sat_len  = (i_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : i_length;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            len_mem[idx]  <= sat_len;
            code_mem[idx] <= i_code;
        end
        if (i_rd_en) begin
            r_rd_len  <= len_mem[idx];
            r_rd_code <= code_mem[idx];
        end
    end

    // An entry that was never loaded reads as length zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en && in_range) begin
                r_valid[idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= in_range && r_valid[idx];
            end
        end
    end

    assign o_entry.length = r_rd_hit ? r_rd_len : '0;
    assign o_entry.code   = r_rd_code;

endmodule

[design/huffman_byte_encoder.sv]
// Top level of the Huffman byte encoder: table lookup, bit packing and byte output.
//
//   Channel   Modport  Dir  Payload                                       Words per item
//   i_in      sink     in   command, symbol, code_value, code_length      one
//   o_out     source   out  kind, packed_byte, last                       zero to four
//
// An input word is taken in every cycle while each item yields at most one result
// and the output is ready. The table read is registered at acceptance; the packing
// stage then combines the code with the pending bits and loads the result register.
// An encode completing n bytes holds the result register until all are sent; the packing
// stage and the input wait behind it, so the output port sets the rate for long codes.
// Reset is synchronous and active low; it empties the pipeline and marks every table
// entry as having no code, and no clearing pass is needed.
module huffman_byte_encoder import hbe_pkg::*; #(
    parameter int MAX_CODE_BITS = 32,
    parameter int SYMBOL_COUNT  = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hbe_in_if.sink   i_in,
    hbe_out_if.source o_out
);

    // Input acceptance. The table writes a load at this edge and reads for every word.
    logic in_accept;

    assign in_accept = i_in.valid && i_in.ready;

    t_entry entry;

    hbe_code_table #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (in_accept && (i_in.command == CMD_LOAD)),
        .i_rd_en  (in_accept),
        .i_sym    (i_in.symbol),
        .i_code   (i_in.code_value),
        .i_length (i_in.code_length),
        .o_entry  (entry)
    );

    // Packing stage: holds the command whose table read is now available.
    logic r_s1_valid;
    t_cmd r_s1_cmd;

    // Pending bits, right-aligned, and how many of them there are.
    logic [ACC_W-1:0]  r_acc;
    logic [FILL_W-1:0] r_fill;

    // Result register: the bytes still to send sit left-aligned in r_out_word.
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_kind;
    logic [CODE_W-1:0] r_out_word;

    // Combinational packing of the current code with the pending bits.
    logic [CODE_W-1:0] code_mask;
    logic [SUM_W-1:0]  joined;
    logic [LEN_W-1:0]  total;
    logic [FILL_W-1:0] enc_fill;
    logic [ACC_W-1:0]  enc_acc;
    logic [SUM_W-1:0]  joined_left;
    logic [BYTE_W-1:0] flush_byte;

    assign code_mask   = ~({CODE_W{1'b1}} << entry.length);
    assign joined      = ({{CODE_W{1'b0}}, r_acc} << entry.length)
                       | {{ACC_W{1'b0}}, entry.code & code_mask};
    assign total       = {{(LEN_W - FILL_W){1'b0}}, r_fill} + entry.length;
    assign enc_fill    = total[FILL_W-1:0];
    assign enc_acc     = joined[ACC_W-1:0] & ~({ACC_W{1'b1}} << enc_fill);
    // The earliest bit lands in the top position; only whole bytes are sent from it.
    assign joined_left = joined << (LEN_W'(SUM_W) - total);
    assign flush_byte  = BYTE_W'({1'b0, r_acc} << (4'(BYTE_W) - {1'b0, r_fill}));

    // Outcome of the packing stage for the word it holds.
    logic [CNT_W-1:0]  res_cnt;
    logic              res_kind;
    logic [CODE_W-1:0] res_word;
    logic              upd_state;
    logic [ACC_W-1:0]  upd_acc;
    logic [FILL_W-1:0] upd_fill;

    always_comb begin
        res_cnt   = '0;
        res_kind  = KIND_DATA;
        res_word  = '0;
        upd_state = 1'b0;
        upd_acc   = r_acc;
        upd_fill  = r_fill;
        case (r_s1_cmd)
            CMD_ENCODE: begin
                if (entry.length == '0) begin
                    // A symbol with no code reports one error and leaves the bits alone.
                    res_cnt  = CNT_W'(1);
                    res_kind = KIND_ERROR;
                end else begin
                    res_cnt   = CNT_W'(total[LEN_W-1:FILL_W]);
                    res_word  = joined_left[SUM_W-1 -: CODE_W];
                    upd_state = 1'b1;
                    upd_acc   = enc_acc;
                    upd_fill  = enc_fill;
                end
            end
            CMD_FLUSH: begin
                if (r_fill != '0) begin
                    res_cnt  = CNT_W'(1);
                    res_word = {flush_byte, {(CODE_W - BYTE_W){1'b0}}};
                end
                upd_state = 1'b1;
                upd_acc   = '0;
                upd_fill  = '0;
            end
            default: begin
                // Loads were written at acceptance; the unused code does nothing.
            end
        endcase
    end

    // The packing stage moves on when its results fit into the result register.
    logic out_pop;
    logic s1_adv;

    assign out_pop = o_out.valid && o_out.ready;
    assign s1_adv  = r_s1_valid
                  && ((res_cnt == '0) || (r_out_cnt == '0)
                      || ((r_out_cnt == CNT_W'(1)) && o_out.ready));

    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_acc      <= '0;
            r_fill     <= '0;
            r_out_cnt  <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && upd_state) begin
                r_acc  <= upd_acc;
                r_fill <= upd_fill;
            end
            if (s1_adv && (res_cnt != '0)) begin
                r_out_cnt <= res_cnt;
            end else if (out_pop) begin
                r_out_cnt <= r_out_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_in.command;
        end
        if (s1_adv && (res_cnt != '0)) begin
            r_out_kind <= res_kind;
            r_out_word <= res_word;
        end else if (out_pop) begin
            r_out_word <= r_out_word << BYTE_W;
        end
    end

    assign o_out.valid       = (r_out_cnt != '0);
    assign o_out.kind        = r_out_kind;
    assign o_out.packed_byte = r_out_word[CODE_W-1 -: BYTE_W];
    assign o_out.last        = (r_out_cnt == CNT_W'(1));

endmodule
